[hdl/rbb_pkg.sv]
// Shared types, register codes and defaults for the region box blur.
`default_nettype none

package rbb_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_PIXEL_BITS = 24;

  // Fixed field widths
  localparam int COORD_W    = 6;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // Register reset values
  localparam logic [SIZE_W-1:0]  RST_IMAGE_ROWS = 7'd64;
  localparam logic [SIZE_W-1:0]  RST_IMAGE_COLS = 7'd64;
  localparam logic [COORD_W-1:0] RST_FIRST_ROW  = 6'd0;
  localparam logic [COORD_W-1:0] RST_FIRST_COL  = 6'd0;
  localparam logic [COORD_W-1:0] RST_LAST_ROW   = 6'd63;
  localparam logic [COORD_W-1:0] RST_LAST_COL   = 6'd63;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_ROWS = 3'd0,
    REG_IMAGE_COLS = 3'd1,
    REG_FIRST_ROW  = 3'd2,
    REG_FIRST_COL  = 3'd3,
    REG_LAST_ROW   = 3'd4,
    REG_LAST_COL   = 3'd5
  } cfg_reg_e;

  // Results one input can release, in emission order
  localparam int EM_UP_LEFT = 0;  // (r-1, c-1)
  localparam int EM_UP      = 1;  // (r-1, c)   on the last column
  localparam int EM_LEFT    = 2;  // (r, c-1)   on the last row
  localparam int EM_SELF    = 3;  // (r, c)     on the last pixel of the frame
  localparam int EM_N       = 4;

  // Neighbourhood size of one result
  typedef enum logic [1:0] {
    DIV_BY_4 = 2'd0,
    DIV_BY_6 = 2'd1,
    DIV_BY_9 = 2'd2
  } div_e;

  // Position info of one input item, worked out when it is accepted
  typedef struct packed {
    logic [EM_N-1:0]    emit;
    logic               row_ge2;
    logic               col_ge2;
    logic               row_in_prev;
    logic               row_in_cur;
    logic               col_in_prev;
    logic               col_in_cur;
    logic [COORD_W-1:0] row_prev;
    logic [COORD_W-1:0] row_cur;
    logic [COORD_W-1:0] col_prev;
    logic [COORD_W-1:0] col_cur;
  } pos_t;

  // Control of one result request from the window to the mean pipeline
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
    logic               blur;
    div_e               div;
  } em_ctrl_t;

endpackage

`default_nettype wire

[hdl/rbb_line_buf.sv]
// Two-line buffer in one synchronous memory, read at accept and written back at commit.
`default_nettype none

module rbb_line_buf #(
  parameter int DEPTH = rbb_pkg::DEF_MAX_COLS,
  parameter int PW    = rbb_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr_i,
  input  wire logic                         commit_i,
  input  wire logic signed [PW-1:0]         pixel_i,
  output logic signed [PW-1:0]              older_o,
  output logic signed [PW-1:0]              prev_o
);

  import rbb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  // Entry holds {older line, previous line} of one column
  logic [2*PW-1:0] mem_q [DEPTH];
  logic [2*PW-1:0] rd_data_q;
  logic [AW-1:0]   addr_q;

  // Consecutive items hit different columns, so the write-back of one item
  // never meets the read of the next at the same entry.
  always_ff @(posedge clk_i) begin
    if (commit_i) begin
      mem_q[addr_q] <= {rd_data_q[PW-1:0], pixel_i};
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
      addr_q    <= rd_addr_i;
    end
  end

  assign older_o = rd_data_q[2*PW-1:PW];
  assign prev_o  = rd_data_q[PW-1:0];

endmodule

`default_nettype wire

[hdl/rbb_window.sv]
// 3x3 window and sequencer: issues a pending result a cycle unless stalled; forms row sums.
`default_nettype none

module rbb_window #(
  parameter int PIXEL_BITS = rbb_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_i,
  output logic                           load_ready_o,
  input  wire rbb_pkg::pos_t             pos_i,
  input  wire logic signed [PIXEL_BITS-1:0] older_i,
  input  wire logic signed [PIXEL_BITS-1:0] prev_i,
  input  wire logic signed [PIXEL_BITS-1:0] pixel_i,
  output logic                           em_valid_o,
  input  wire logic                      em_ready_i,
  output rbb_pkg::em_ctrl_t              em_ctrl_o,
  output logic signed [PIXEL_BITS+1:0]   rs0_o,
  output logic signed [PIXEL_BITS+1:0]   rs1_o,
  output logic signed [PIXEL_BITS+1:0]   rs2_o,
  output logic signed [PIXEL_BITS-1:0]   pass_o
);

  import rbb_pkg::*;

  localparam int P   = PIXEL_BITS;
  localparam int RSW = P + 2;

  logic signed [P-1:0] w_q [3][3];
  pos_t                pos_q;
  logic [EM_N-1:0]     pend_q, pend_d;
  logic [EM_N-1:0]     sel_oh;
  logic                issue;
  logic                wr1, wc1, row0_inc, col0_inc;
  logic signed [RSW-1:0] rs [3];

  // Lowest pending result goes first
  always_comb begin
    sel_oh = '0;
    priority if (pend_q[EM_UP_LEFT]) begin
      sel_oh[EM_UP_LEFT] = 1'b1;
    end else if (pend_q[EM_UP]) begin
      sel_oh[EM_UP] = 1'b1;
    end else if (pend_q[EM_LEFT]) begin
      sel_oh[EM_LEFT] = 1'b1;
    end else if (pend_q[EM_SELF]) begin
      sel_oh[EM_SELF] = 1'b1;
    end
  end

  assign em_valid_o = |pend_q;
  assign issue      = em_valid_o && em_ready_i;

  always_comb begin
    pend_d = issue ? (pend_q & ~sel_oh) : pend_q;
    // Take the next item once the current one has nothing left after this cycle
    load_ready_o = (pend_d == '0);
    if (load_i) begin
      pend_d = pos_i.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Shift the window left and bring in the new column
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int k = 0; k < 3; k++) begin
        w_q[k][0] <= w_q[k][1];
        w_q[k][1] <= w_q[k][2];
      end
      w_q[0][2] <= older_i;
      w_q[1][2] <= prev_i;
      w_q[2][2] <= pixel_i;
      pos_q     <= pos_i;
    end
  end

  // Result centre sits at window row/col 1 or 2
  assign wr1      = sel_oh[EM_UP_LEFT] || sel_oh[EM_UP];
  assign wc1      = sel_oh[EM_UP_LEFT] || sel_oh[EM_LEFT];
  assign row0_inc = wr1 && pos_q.row_ge2;
  assign col0_inc = wc1 && pos_q.col_ge2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rs[k] = (col0_inc ? RSW'(w_q[k][0]) : '0) + RSW'(w_q[k][1]) + RSW'(w_q[k][2]);
    end
  end

  assign rs0_o = row0_inc ? rs[0] : '0;
  assign rs1_o = rs[1];
  assign rs2_o = rs[2];
  assign pass_o = wr1 ? (wc1 ? w_q[1][1] : w_q[1][2]) : (wc1 ? w_q[2][1] : w_q[2][2]);

  always_comb begin
    em_ctrl_o.row  = wr1 ? pos_q.row_prev : pos_q.row_cur;
    em_ctrl_o.col  = wc1 ? pos_q.col_prev : pos_q.col_cur;
    em_ctrl_o.last = sel_oh[EM_SELF];
    em_ctrl_o.blur = (wr1 ? pos_q.row_in_prev : pos_q.row_in_cur) &&
                     (wc1 ? pos_q.col_in_prev : pos_q.col_in_cur);
    if (row0_inc && col0_inc) begin
      em_ctrl_o.div = DIV_BY_9;
    end else if (row0_inc || col0_inc) begin
      em_ctrl_o.div = DIV_BY_6;
    end else begin
      em_ctrl_o.div = DIV_BY_4;
    end
  end

endmodule

`default_nettype wire

[hdl/rbb_mean.sv]
// Mean pipeline: total, rounded magnitude, reciprocal multiply, correction and output register.
`default_nettype none

module rbb_mean #(
  parameter int PIXEL_BITS = rbb_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire rbb_pkg::em_ctrl_t            ctrl_i,
  input  wire logic signed [PIXEL_BITS+1:0] rs0_i,
  input  wire logic signed [PIXEL_BITS+1:0] rs1_i,
  input  wire logic signed [PIXEL_BITS+1:0] rs2_i,
  input  wire logic signed [PIXEL_BITS-1:0] pass_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [rbb_pkg::COORD_W-1:0]       out_row_o,
  output logic [rbb_pkg::COORD_W-1:0]       out_col_o,
  output logic signed [PIXEL_BITS-1:0]      pixel_out_o,
  output logic                              frame_last_o
);

  import rbb_pkg::*;

  localparam int P   = PIXEL_BITS;
  localparam int RSW = P + 2;
  localparam int SW  = P + 4;        // sum of nine pixels
  localparam int NW  = P + 3;        // rounded magnitude
  localparam int KW  = NW - 1;       // reciprocal
  localparam int QW  = NW - 2;       // quotient
  localparam int PRW = NW + KW;

  localparam logic [63:0] K4_FULL = (64'd1 << NW) / 64'd4;
  localparam logic [63:0] K6_FULL = (64'd1 << NW) / 64'd6;
  localparam logic [63:0] K9_FULL = (64'd1 << NW) / 64'd9;
  localparam logic [KW-1:0] K4 = K4_FULL[KW-1:0];
  localparam logic [KW-1:0] K6 = K6_FULL[KW-1:0];
  localparam logic [KW-1:0] K9 = K9_FULL[KW-1:0];

  // Stage A: row sums
  logic                  a_valid_q, a_ready;
  em_ctrl_t              a_ctrl_q;
  logic signed [RSW-1:0] a_rs0_q, a_rs1_q, a_rs2_q;
  logic signed [P-1:0]   a_pass_q;
  // Stage B: signed total
  logic                  b_valid_q, b_ready;
  em_ctrl_t              b_ctrl_q;
  logic signed [SW-1:0]  b_sum_q;
  logic signed [P-1:0]   b_pass_q;
  // Stage C: magnitude plus half divisor
  logic                  c_valid_q, c_ready;
  em_ctrl_t              c_ctrl_q;
  logic [NW-1:0]         c_n_q;
  logic                  c_neg_q;
  logic signed [P-1:0]   c_pass_q;
  // Stage D: product with the reciprocal
  logic                  d_valid_q, d_ready;
  em_ctrl_t              d_ctrl_q;
  logic [PRW-1:0]        d_prod_q;
  logic [NW-1:0]         d_n_q;
  logic                  d_neg_q;
  logic signed [P-1:0]   d_pass_q;
  // Output register
  logic                  o_valid_q, o_ready;
  em_ctrl_t              o_ctrl_q;
  logic signed [P-1:0]   o_pixel_q;

  logic [2:0]    half;
  logic [SW-1:0] half_ext, n_full;
  logic [KW-1:0] k_sel;
  logic [QW-1:0] q_est, q_fix, q_neg;
  logic [NW-1:0] dq, rem, dval;
  logic          c_take, d_take;

  assign o_ready    = !o_valid_q || !out_stall_i;
  assign d_ready    = !d_valid_q || o_ready;
  assign c_ready    = !c_valid_q || d_ready;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
      if (d_ready) d_valid_q <= c_valid_q;
      if (o_ready) o_valid_q <= d_valid_q;
    end
  end

  // Rounding offset and reciprocal for the divisor
  always_comb begin
    unique case (b_ctrl_q.div)
      DIV_BY_6: half = 3'd3;
      DIV_BY_9: half = 3'd4;
      default:  half = 3'd2;
    endcase
    unique case (c_ctrl_q.div)
      DIV_BY_6: k_sel = K6;
      DIV_BY_9: k_sel = K9;
      default:  k_sel = K4;
    endcase
  end

  assign half_ext = SW'(half);
  assign n_full   = b_sum_q[SW-1] ? (half_ext - $unsigned(b_sum_q))
                                  : ($unsigned(b_sum_q) + half_ext);

  // Quotient estimate is exact or one short; one compare fixes it
  assign q_est = d_prod_q[NW +: QW];
  always_comb begin
    unique case (d_ctrl_q.div)
      DIV_BY_6: begin
        dq   = NW'({q_est, 2'b00}) + NW'({q_est, 1'b0});
        dval = NW'(6);
      end
      DIV_BY_9: begin
        dq   = NW'({q_est, 3'b000}) + NW'(q_est);
        dval = NW'(9);
      end
      default: begin
        dq   = NW'({q_est, 2'b00});
        dval = NW'(4);
      end
    endcase
  end
  assign rem   = d_n_q - dq;
  assign q_fix = (rem >= dval) ? (q_est + QW'(1)) : q_est;
  assign q_neg = d_neg_q ? (~q_fix + QW'(1)) : q_fix;

  assign c_take = b_valid_q && c_ready;
  assign d_take = c_valid_q && d_ready;

  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      a_ctrl_q <= ctrl_i;
      a_rs0_q  <= rs0_i;
      a_rs1_q  <= rs1_i;
      a_rs2_q  <= rs2_i;
      a_pass_q <= pass_i;
    end
    if (b_ready) begin
      b_ctrl_q <= a_ctrl_q;
      b_sum_q  <= SW'(a_rs0_q) + SW'(a_rs1_q) + SW'(a_rs2_q);
      b_pass_q <= a_pass_q;
    end
    if (c_take) begin
      c_ctrl_q <= b_ctrl_q;
      c_n_q    <= n_full[NW-1:0];
      c_neg_q  <= b_sum_q[SW-1];
      c_pass_q <= b_pass_q;
    end
    if (d_take) begin
      d_ctrl_q <= c_ctrl_q;
      d_prod_q <= PRW'(c_n_q) * PRW'(k_sel);
      d_n_q    <= c_n_q;
      d_neg_q  <= c_neg_q;
      d_pass_q <= c_pass_q;
    end
    if (d_valid_q && o_ready) begin
      o_ctrl_q  <= d_ctrl_q;
      o_pixel_q <= d_ctrl_q.blur ? $signed(q_neg[P-1:0]) : d_pass_q;
    end
  end

  assign out_valid_o  = o_valid_q;
  assign out_row_o    = o_ctrl_q.row;
  assign out_col_o    = o_ctrl_q.col;
  assign pixel_out_o  = o_pixel_q;
  assign frame_last_o = o_ctrl_q.last;

endmodule

`default_nettype wire

[hdl/region_box_blur_3x3.sv]
// Top level of the region box blur: registers, raster counters, line buffer, window, mean.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+--------------------------------------
//   input    | in        | in_valid_i / in_stall_o   | pixel_in_i
//   output   | out       | out_valid_o / out_stall_i | out_row_o, out_col_o, pixel_out_o,
//            |           |                           | frame_last_o
//   config   | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel request is taken per clock while results keep flowing; the first result of a pixel
// reaches the output register through the line read, the window and four mean stages.
// The window sequencer issues one result per cycle while the mean pipeline takes them, so
// pixels that release two or four results hold the input until all of them are issued. Reset
// clears counters, registers and valid bits; line buffer contents are left as they are and
// rows not yet received are never read. Stalls back up stage by stage, and bubbles close up,
// so a stalled output still lets upstream stages fill.
`default_nettype none

module region_box_blur_3x3 #(
  parameter int MAX_COLS   = rbb_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = rbb_pkg::DEF_MAX_ROWS,
  parameter int PIXEL_BITS = rbb_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // pixel requests
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic signed [PIXEL_BITS-1:0]     pixel_in_i,
  // results
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [rbb_pkg::COORD_W-1:0]           out_row_o,
  output logic [rbb_pkg::COORD_W-1:0]           out_col_o,
  output logic signed [PIXEL_BITS-1:0]          pixel_out_o,
  output logic                                  frame_last_o,
  // register writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [rbb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [rbb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import rbb_pkg::*;

  localparam int P  = PIXEL_BITS;
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  // widths that hold the clamped size and the region bounds next to the counters
  localparam int LR = ($clog2(MAX_ROWS + 1) > SIZE_W) ? $clog2(MAX_ROWS + 1) : SIZE_W;
  localparam int LC = ($clog2(MAX_COLS + 1) > SIZE_W) ? $clog2(MAX_COLS + 1) : SIZE_W;
  localparam int GR = (RW > COORD_W) ? RW : COORD_W;
  localparam int GC = (CW > COORD_W) ? CW : COORD_W;

  // Configuration registers
  logic [SIZE_W-1:0]  image_rows_q, image_cols_q;
  logic [COORD_W-1:0] first_row_q, first_col_q, last_row_q, last_col_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_rows_q <= RST_IMAGE_ROWS;
      image_cols_q <= RST_IMAGE_COLS;
      first_row_q  <= RST_FIRST_ROW;
      first_col_q  <= RST_FIRST_COL;
      last_row_q   <= RST_LAST_ROW;
      last_col_q   <= RST_LAST_COL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_ROWS: image_rows_q <= cfg_data_i;
        REG_IMAGE_COLS: image_cols_q <= cfg_data_i;
        REG_FIRST_ROW:  first_row_q  <= cfg_data_i[COORD_W-1:0];
        REG_FIRST_COL:  first_col_q  <= cfg_data_i[COORD_W-1:0];
        REG_LAST_ROW:   last_row_q   <= cfg_data_i[COORD_W-1:0];
        REG_LAST_COL:   last_col_q   <= cfg_data_i[COORD_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Clamp the image size to 2..MAX
  logic [LR-1:0] rows_x, rows_eff;
  logic [LC-1:0] cols_x, cols_eff;

  assign rows_x = LR'(image_rows_q);
  assign cols_x = LC'(image_cols_q);

  always_comb begin
    if (rows_x < LR'(2)) begin
      rows_eff = LR'(2);
    end else if (rows_x > LR'(MAX_ROWS)) begin
      rows_eff = LR'(MAX_ROWS);
    end else begin
      rows_eff = rows_x;
    end
    if (cols_x < LC'(2)) begin
      cols_eff = LC'(2);
    end else if (cols_x > LC'(MAX_COLS)) begin
      cols_eff = LC'(MAX_COLS);
    end else begin
      cols_eff = cols_x;
    end
  end

  // Raster position of the next pixel
  logic [RW-1:0] row_q, row_d, row_prev;
  logic [CW-1:0] col_q, col_d, col_prev;
  logic          last_row, last_col, row_ge1, col_ge1;
  logic          accept;
  pos_t          pos_d;

  assign last_row = LR'(row_q) >= (rows_eff - LR'(1));
  assign last_col = LC'(col_q) >= (cols_eff - LC'(1));
  assign row_ge1  = row_q != '0;
  assign col_ge1  = col_q != '0;
  assign row_prev = row_q - RW'(1);
  assign col_prev = col_q - CW'(1);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : (row_q + RW'(1));
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Which results this pixel releases, and where they fall against the region
  always_comb begin
    pos_d.emit[EM_UP_LEFT] = row_ge1 && col_ge1;
    pos_d.emit[EM_UP]      = row_ge1 && last_col;
    pos_d.emit[EM_LEFT]    = last_row && col_ge1;
    pos_d.emit[EM_SELF]    = last_row && last_col;
    pos_d.row_ge2     = row_q > RW'(1);
    pos_d.col_ge2     = col_q > CW'(1);
    pos_d.row_in_prev = (GR'(row_prev) >= GR'(first_row_q)) &&
                        (GR'(row_prev) <= GR'(last_row_q));
    pos_d.row_in_cur  = (GR'(row_q) >= GR'(first_row_q)) &&
                        (GR'(row_q) <= GR'(last_row_q));
    pos_d.col_in_prev = (GC'(col_prev) >= GC'(first_col_q)) &&
                        (GC'(col_prev) <= GC'(last_col_q));
    pos_d.col_in_cur  = (GC'(col_q) >= GC'(first_col_q)) &&
                        (GC'(col_q) <= GC'(last_col_q));
    pos_d.row_prev    = COORD_W'(row_prev);
    pos_d.row_cur     = COORD_W'(row_q);
    pos_d.col_prev    = COORD_W'(col_prev);
    pos_d.col_cur     = COORD_W'(col_q);
  end

  // Line-read stage: holds the pixel while the buffer read completes
  logic                s1_valid_q, s1_ready;
  logic signed [P-1:0] s1_pixel_q;
  pos_t                s1_pos_q;
  logic                win_load, win_load_ready;

  assign s1_ready   = !s1_valid_q || win_load_ready;
  assign accept     = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;
  assign win_load   = s1_valid_q && win_load_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pixel_q <= pixel_in_i;
      s1_pos_q   <= pos_d;
    end
  end

  logic signed [P-1:0] older, prev;

  rbb_line_buf #(
    .DEPTH (MAX_COLS),
    .PW    (P)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .commit_i  (win_load),
    .pixel_i   (s1_pixel_q),
    .older_o   (older),
    .prev_o    (prev)
  );

  logic                em_valid, em_ready;
  em_ctrl_t            em_ctrl;
  logic signed [P+1:0] rs0, rs1, rs2;
  logic signed [P-1:0] pass;

  rbb_window #(
    .PIXEL_BITS (P)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (win_load),
    .load_ready_o (win_load_ready),
    .pos_i        (s1_pos_q),
    .older_i      (older),
    .prev_i       (prev),
    .pixel_i      (s1_pixel_q),
    .em_valid_o   (em_valid),
    .em_ready_i   (em_ready),
    .em_ctrl_o    (em_ctrl),
    .rs0_o        (rs0),
    .rs1_o        (rs1),
    .rs2_o        (rs2),
    .pass_o       (pass)
  );

  rbb_mean #(
    .PIXEL_BITS (P)
  ) u_mean (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (em_valid),
    .in_ready_o   (em_ready),
    .ctrl_i       (em_ctrl),
    .rs0_i        (rs0),
    .rs1_i        (rs1),
    .rs2_i        (rs2),
    .pass_i       (pass),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

endmodule

`default_nettype wire
